// File: rtl/core/kmpd_pkg.sv
// Shared types, constants and the key map function for the key matrix press detector.
package kmpd_pkg;

    // Width of the column field of one scanned row.
    localparam int unsigned IN_COLS = 4;

    // Depth of the queue between the front and back halves.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Physical rows that carry mapped keys.
    localparam logic [2:0] MAP_ROWS = 3'd6;

    // One scanned row as it arrives.
    typedef struct packed {
        logic [2:0]         row_index;
        logic [IN_COLS-1:0] col_down;
    } t_row_item;

    // One press event as it leaves.
    typedef struct packed {
        logic [2:0] key_row;
        logic [1:0] key_col;
        logic       last;
    } t_press_result;

    // One row of work: the row and the columns that give a press event.
    typedef struct packed {
        logic [2:0]         row_index;
        logic [IN_COLS-1:0] mask;
    } t_work;

    // Queue status as seen by its neighbours.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Result of a key map lookup.
    typedef struct packed {
        logic       valid;
        logic [2:0] lrow;
        logic [1:0] lcol;
    } t_key_entry;

    // Physical to logical key map. Keys outside the map come back invalid.
    function automatic t_key_entry key_map(input logic [2:0] prow, input logic [1:0] pcol);
        t_key_entry e;
        e.valid = 1'b1;
        e.lrow  = prow;
        e.lcol  = pcol;
        if (prow >= MAP_ROWS) begin
            e.valid = 1'b0;
        end else if (prow == 3'd0) begin
            // Only the last column of the top row is wired, and it sits at column zero.
            e.valid = (pcol == 2'd3);
            e.lcol  = 2'd0;
        end else if (prow == 3'd5) begin
            // The bottom row has no key at column two, and its column-three key maps to column two.
            e.valid = (pcol != 2'd2);
            if (pcol == 2'd3) begin
                e.lcol = 2'd2;
            end
        end else if (prow == 3'd2 || prow == 3'd4) begin
            e.valid = (pcol != 2'd3);
        end
        return e;
    endfunction

endpackage

// File: rtl/core/key_matrix_press_detector_top.sv
// Top level of the key matrix press detector.
// Each request on the input side is one scanned row (row index and four column bits,
// 1 = key down). A row is taken whenever full is low, and its newly pressed mapped
// keys come out as press events in column order, one per cycle while pop is high,
// with last set on the final event of that row; a row with no new mapped press gives
// no event. The single result port of the back half paces the rows that give events;
// a two-row queue between the front and back halves lets rows keep arriving while
// events wait to be popped. Row indexes of ROWS or more are ignored. The pressed map
// is cleared by reset.
module key_matrix_press_detector_top #(
    parameter int unsigned ROWS = 6,
    parameter int unsigned COLS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  kmpd_pkg::t_row_item       i_item,
    output logic                      empty,
    input  logic                      pop,
    output kmpd_pkg::t_press_result   o_result
);
    import kmpd_pkg::*;

    logic      accept;
    logic      q_push;
    logic      q_pop;
    t_work     q_wdata;
    t_work     q_rdata;
    t_q_status q_status;

    assign full   = q_status.full;
    assign accept = push & ~q_status.full;

    // Front half: classify each row.
    kmpd_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    // Queue between the halves.
    kmpd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wdata),
        .i_pop    (q_pop),
        .o_data   (q_rdata),
        .o_status (q_status)
    );

    // Back half: emit the events.
    kmpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (q_rdata),
        .i_q_status (q_status),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule

// File: rtl/core/kmpd_front.sv
// Front half: accepts scanned rows, keeps the pressed map and finds new presses.
module kmpd_front #(
    parameter int unsigned ROWS = 6,
    parameter int unsigned COLS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  kmpd_pkg::t_row_item  i_item,
    output logic                 o_q_push,
    output kmpd_pkg::t_work      o_q_data
);
    import kmpd_pkg::*;

    localparam int unsigned IDX_W = $clog2(ROWS);

    logic [COLS-1:0]  r_map [ROWS];
    logic [IDX_W-1:0] row_idx;
    logic             row_ok;
    logic [COLS-1:0]  new_bits;
    logic [COLS-1:0]  old_bits;
    logic [COLS-1:0]  rise;
    logic [IN_COLS-1:0] mask;
    t_key_entry       entry [IN_COLS];

    // Decode the row and compare with what was down on its last scan.
    assign row_idx  = IDX_W'(i_item.row_index);
    assign row_ok   = 32'(i_item.row_index) < 32'(ROWS);
    assign new_bits = COLS'(i_item.col_down);
    assign old_bits = r_map[row_idx];
    assign rise     = new_bits & ~old_bits;

    // Keep only the rising columns that land on a mapped key.
    always_comb begin
        for (int c = 0; c < IN_COLS; c++) begin
            entry[c] = key_map(i_item.row_index, 2'(c));
            mask[c]  = rise[c] & entry[c].valid;
        end
    end

    // Rows that give at least one event go to the back half.
    assign o_q_push           = i_accept & row_ok & (|mask);
    assign o_q_data.row_index = i_item.row_index;
    assign o_q_data.mask      = mask;

    // The pressed map takes the new bits of every in-range row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_map[r] <= '0;
            end
        end else if (i_accept && row_ok) begin
            r_map[row_idx] <= new_bits;
        end
    end

`ifndef SYNTH
    // A queued row always holds at least one press event.
    a_push_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> (o_q_data.mask != '0))
        else $error("front pushed an empty row");

    // An out-of-range row never reaches the back half.
    a_push_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> row_ok)
        else $error("front pushed an out-of-range row");
`endif

endmodule

// File: rtl/core/kmpd_queue.sv
// Short queue of rows of work between the front and back halves.
module kmpd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  kmpd_pkg::t_work      i_data,
    input  logic                 i_pop,
    output kmpd_pkg::t_work      o_data,
    output kmpd_pkg::t_q_status  o_status
);
    import kmpd_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_work            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd_ptr];

    assign do_push = i_push & ~o_status.full;
    assign do_pop  = i_pop & ~o_status.empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count overflow");
`endif

endmodule

// File: rtl/core/kmpd_back.sv
// Back half: turns each queued row into press events, one per cycle while popped, in column order.
module kmpd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  kmpd_pkg::t_work        i_q_data,
    input  kmpd_pkg::t_q_status    i_q_status,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output kmpd_pkg::t_press_result o_result
);
    import kmpd_pkg::*;

    logic               r_valid;
    logic [2:0]         r_row;
    logic [IN_COLS-1:0] r_mask;
    logic               n_valid;
    logic [2:0]         n_row;
    logic [IN_COLS-1:0] n_mask;
    logic [IN_COLS-1:0] sel;
    logic [1:0]         sel_col;
    logic               cur_last;
    logic               taken;
    logic               done;
    logic               load;
    t_key_entry         entry;

    // Lowest remaining column is the next event.
    assign sel      = r_mask & (~r_mask + 1'b1);
    assign cur_last = ((r_mask & ~sel) == '0);

    always_comb begin
        sel_col = 2'd0;
        for (int c = IN_COLS - 1; c >= 0; c--) begin
            if (sel[c]) begin
                sel_col = 2'(c);
            end
        end
    end

    // Present the current event.
    assign entry            = key_map(r_row, sel_col);
    assign o_empty          = ~r_valid;
    assign o_result.key_row = entry.lrow;
    assign o_result.key_col = entry.lcol;
    assign o_result.last    = cur_last;

    // Step through the row and fetch the next one when it is finished.
    assign taken   = r_valid & i_pop;
    assign done    = taken & cur_last;
    assign load    = (~r_valid | done) & ~i_q_status.empty;
    assign o_q_pop = load;

    always_comb begin
        n_valid = r_valid;
        n_row   = r_row;
        n_mask  = r_mask;
        if (load) begin
            n_valid = 1'b1;
            n_row   = i_q_data.row_index;
            n_mask  = i_q_data.mask;
        end else if (done) begin
            n_valid = 1'b0;
        end else if (taken) begin
            n_mask = r_mask & ~sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_row  <= n_row;
        r_mask <= n_mask;
    end

`ifndef SYNTH
    // A held row always has an event left to give.
    a_mask_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_mask != '0))
        else $error("back holds a row with no events");

    // Taking an event that is not the last keeps the row in place.
    a_row_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (taken && !cur_last) |=> (r_valid && $stable(r_row)))
        else $error("back dropped a row before its last event");
`endif

endmodule

// File: bench/tb_key_matrix_press_detector_top.sv
// Self-checking testbench for the key matrix press detector top level.
module tb_key_matrix_press_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kmpd_pkg::*;

    localparam int unsigned SCAN_ROWS    = 6;
    localparam int unsigned MAX_GAP      = 13;
    localparam int unsigned RANDOM_ROWS  = 130;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam longint unsigned CYCLE_LIMIT = 200000;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          push    = 1'b0;
    logic          pop     = 1'b0;
    t_row_item     i_item  = '0;
    logic          full;
    logic          empty;
    t_press_result o_result;

    // Predictor state: which keys were down on the last scan of each row.
    logic [IN_COLS-1:0] held_keys [0:SCAN_ROWS-1];
    t_press_result      expected_presses [$];

    int          mismatch_count = 0;
    longint      cycle_count    = 0;
    int unsigned rx_hold_cycles = 0;
    bit          tx_burst       = 1'b0;
    bit          rx_burst       = 1'b0;

    key_matrix_press_detector_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #5ns i_clk = ~i_clk;

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("key_matrix_press_detector_top regression: fail");
        $finish;
    end

    // Physical to logical key lookup, written out key by key.
    function automatic t_key_entry lookup_key(input logic [2:0] prow, input logic [1:0] pcol);
        t_key_entry k;
        k.valid = 1'b1;
        k.lrow  = prow;
        k.lcol  = pcol;
        if (prow >= 3'd6) begin
            k.valid = 1'b0;
        end else begin
            case ({prow, pcol})
                {3'd0, 2'd0}, {3'd0, 2'd1}, {3'd0, 2'd2},
                {3'd2, 2'd3}, {3'd4, 2'd3}, {3'd5, 2'd2}: begin
                    k.valid = 1'b0;
                end
                {3'd0, 2'd3}: begin
                    k.lcol = 2'd0;
                end
                {3'd5, 2'd3}: begin
                    k.lcol = 2'd2;
                end
                default: begin
                end
            endcase
        end
        return k;
    endfunction

    // Work out the press events of one accepted row and update the held keys.
    function automatic void predict_presses(input t_row_item row_req);
        t_press_result ev;
        t_key_entry    k;
        int            first_idx;
        int            n_events;
        first_idx = expected_presses.size();
        n_events  = 0;
        if (row_req.row_index < SCAN_ROWS) begin
            for (int c = 0; c < IN_COLS; c++) begin
                if (row_req.col_down[c] && !held_keys[row_req.row_index][c]) begin
                    k = lookup_key(row_req.row_index, c[1:0]);
                    if (k.valid) begin
                        ev.key_row = k.lrow;
                        ev.key_col = k.lcol;
                        ev.last    = 1'b0;
                        expected_presses.push_back(ev);
                        n_events++;
                    end
                end
            end
            held_keys[row_req.row_index] = row_req.col_down;
            if (n_events > 0) begin
                expected_presses[first_idx + n_events - 1].last = 1'b1;
            end
        end
    endfunction

    // Offer one row request after a random gap and hold it until it is taken.
    task automatic send_row(input t_row_item row_req, input bit back_to_back);
        int unsigned gap;
        gap = (back_to_back || tx_burst) ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 19) == 0) begin
            tx_burst = ~tx_burst;
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= row_req;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        predict_presses(row_req);
    endtask

    // Stop offering and wait until every predicted press event has arrived.
    task automatic drain_presses();
        push <= 1'b0;
        do @(posedge i_clk); while (expected_presses.size() != 0);
    endtask

    function automatic t_row_item make_row(input logic [2:0] r, input logic [3:0] c);
        t_row_item it;
        it.row_index = r;
        it.col_down  = c;
        return it;
    endfunction

    // Receiver: random stalls, bursts without stalls, and the occasional long hold-off.
    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 15) == 0) begin
                    rx_burst = ~rx_burst;
                end
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // Compare every accepted press event with the oldest prediction.
    always @(posedge i_clk) begin
        t_press_result want;
        if (i_rst_n && pop && !empty) begin
            if (expected_presses.size() == 0) begin
                $display("%0t: unexpected press event row=%0d col=%0d last=%0b", $time,
                         o_result.key_row, o_result.key_col, o_result.last);
                mismatch_count++;
            end else begin
                want = expected_presses.pop_front();
                if (o_result.key_row !== want.key_row) begin
                    $display("%0t: key_row expected %0d actual %0d", $time,
                             want.key_row, o_result.key_row);
                    mismatch_count++;
                end
                if (o_result.key_col !== want.key_col) begin
                    $display("%0t: key_col expected %0d actual %0d", $time,
                             want.key_col, o_result.key_col);
                    mismatch_count++;
                end
                if (o_result.last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, o_result.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Key map corners, remapped and unmapped keys, repeats, releases and ignored rows.
    task automatic test_directed_rows();
        send_row(make_row(3'd0, 4'hF), 1'b0);
        send_row(make_row(3'd0, 4'hF), 1'b0);
        send_row(make_row(3'd0, 4'h0), 1'b0);
        send_row(make_row(3'd0, 4'h7), 1'b0);
        send_row(make_row(3'd1, 4'hF), 1'b0);
        send_row(make_row(3'd2, 4'hF), 1'b0);
        send_row(make_row(3'd3, 4'hF), 1'b0);
        send_row(make_row(3'd4, 4'hF), 1'b0);
        send_row(make_row(3'd5, 4'hF), 1'b0);
        send_row(make_row(3'd5, 4'h4), 1'b0);
        send_row(make_row(3'd5, 4'hC), 1'b0);
        send_row(make_row(3'd6, 4'hF), 1'b0);
        send_row(make_row(3'd7, 4'hF), 1'b0);
        send_row(make_row(3'd7, 4'h0), 1'b0);
        send_row(make_row(3'd3, 4'h0), 1'b0);
        send_row(make_row(3'd3, 4'h5), 1'b0);
        send_row(make_row(3'd3, 4'hA), 1'b0);
        send_row(make_row(3'd1, 4'h0), 1'b0);
        send_row(make_row(3'd1, 4'h8), 1'b0);
        send_row(make_row(3'd2, 4'h0), 1'b0);
        send_row(make_row(3'd2, 4'h8), 1'b0);
        send_row(make_row(3'd4, 4'h0), 1'b0);
        send_row(make_row(3'd4, 4'h9), 1'b0);
        send_row(make_row(3'd0, 4'h0), 1'b0);
        send_row(make_row(3'd0, 4'h8), 1'b0);
        drain_presses();
    endtask

    // The receiver holds off while rows keep coming, so the block fills and raises full.
    task automatic test_receiver_hold_off();
        logic [2:0] r;
        rx_hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 24; i++) begin
            r = ((i / 2) % 2 != 0) ? 3'd3 : 3'd1;
            send_row(make_row(r, (i % 2 != 0) ? 4'h0 : 4'hF), 1'b1);
        end
        drain_presses();
    endtask

    // Random scans: mostly valid rows with frequent releases, some ignored rows.
    task automatic test_random_scan();
        int unsigned counted;
        t_row_item   it;
        counted = 0;
        while (counted < RANDOM_ROWS) begin
            if ($urandom_range(0, 15) == 0) begin
                it.row_index = 3'($urandom_range(SCAN_ROWS, 7));
            end else begin
                it.row_index = 3'($urandom_range(0, SCAN_ROWS - 1));
                counted++;
            end
            it.col_down = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(0, 15));
            send_row(it, 1'b0);
        end
        drain_presses();
    endtask

    // The sender pauses between bursts until every press event has come out.
    task automatic test_sender_pause();
        for (int b = 0; b < 3; b++) begin
            for (int i = 0; i < 8; i++) begin
                send_row(make_row(3'($urandom_range(0, SCAN_ROWS - 1)),
                                  4'($urandom_range(0, 15))), 1'b0);
            end
            drain_presses();
        end
    endtask

    initial begin
        for (int r = 0; r < SCAN_ROWS; r++) begin
            held_keys[r] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_rows();
        test_receiver_hold_off();
        test_random_scan();
        test_sender_pause();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_presses.size() == 0) begin
            $display("key_matrix_press_detector_top regression: pass");
        end else begin
            $display("key_matrix_press_detector_top regression: fail");
        end
        $finish;
    end

endmodule
